FILE: rtl/core/first_fit_aligned_block_allocator_assert.svh
// Assertion macros for the first-fit aligned block allocator
`ifndef FIRST_FIT_ALIGNED_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_ALIGNED_BLOCK_ALLOCATOR_ASSERT_SVH

// Implication checked at every rising edge outside reset
`define FFA_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define FFA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

FILE: rtl/core/ffa_pkg.sv
// Shared types and constants of the first-fit aligned block allocator
package ffa_pkg;

    localparam logic [31:0] RESET_ARENA = 32'h4000_0000;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] req_size;
        logic [4:0]  align_log2;
        logic [31:0] free_offset;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] grant_offset;
        logic [31:0] grant_size;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;    // capture request, clear scan index
        logic init_table;  // rebuild entry zero, count one
        logic eval;        // evaluate returned entry
        logic advance;     // step scan index
        logic commit;      // write back the hit
        logic split;       // write the tail entry
        logic set_result;  // latch the result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic oversize;
        logic scan_done;   // index reached count
        logic hit;         // evaluated entry matches
        logic need_split;
        logic table_full;
    } dp_stat_t;

endpackage

FILE: rtl/core/ffa_ram.sv
// Generic single-port-write, registered-read RAM
module ffa_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/ffa_datapath.sv
// Datapath: entry table, scan index, fit evaluation and result register
module ffa_datapath #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ffa_pkg::dp_cmd_t    cmd,
    output ffa_pkg::dp_stat_t   stat,
    input  ffa_pkg::in_item_t   req,
    input  logic [31:0]         arena_size,
    output ffa_pkg::out_item_t  result
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    ffa_pkg::in_item_t  req_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic [31:0]        hit_off_reg;   // aligned offset
    logic [31:0]        hit_tail_reg;  // avail - size
    logic               hit_reg;
    logic               split_reg;
    ffa_pkg::out_item_t result_reg;

    logic               we;
    logic [IW-1:0]      waddr;
    logic [64:0]        wdata;
    logic [64:0]        rdata;

    ffa_ram #(.WIDTH(65), .DEPTH(MAX_BLOCKS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rdata)
    );

    // entry word: {free, offset, size}
    logic        e_free;
    logic [31:0] e_off, e_size;
    logic [32:0] align_v, rem, pad, avail, tail;
    logic [31:0] aligned_off;
    logic        alloc_fit, free_match;

    assign e_free = rdata[64];
    assign e_off  = rdata[63:32];
    assign e_size = rdata[31:0];

    always_comb
    begin
        align_v     = 33'd1 << req_reg.align_log2;
        rem         = {1'b0, e_off} & (align_v - 33'd1);
        pad         = (rem != 33'd0) ? align_v - rem : 33'd0;
        avail       = {1'b0, e_size} - pad;
        tail        = avail - {1'b0, req_reg.req_size};
        aligned_off = e_off + pad[31:0];
        alloc_fit   = e_free && (pad <= {1'b0, e_size})
                      && (avail >= {1'b0, req_reg.req_size});
        free_match  = !e_free && (e_off == req_reg.free_offset)
                      && (e_size == req_reg.req_size);
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (cmd.init_table)
        begin
            we    = 1'b1;
            wdata = {1'b1, 32'd0, arena_size};
        end
        else if (cmd.commit)
        begin
            we    = 1'b1;
            waddr = hit_idx_reg;
            if (req_reg.mode == ffa_pkg::MODE_FREE)
            begin
                wdata = {1'b1, req_reg.free_offset, req_reg.req_size};
            end
            else
            begin
                wdata = {1'b0, hit_off_reg, req_reg.req_size};
            end
        end
        else if (cmd.split)
        begin
            we    = 1'b1;
            waddr = count_reg[IW-1:0];
            wdata = {1'b1, hit_off_reg + req_reg.req_size, hit_tail_reg};
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.init_table)
        begin
            count_next = CW'(1);
        end
        else if (cmd.split)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(1);
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            split_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load_req)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            else if (cmd.advance)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.eval)
            begin
                hit_reg   <= (req_reg.mode == ffa_pkg::MODE_FREE) ? free_match : alloc_fit;
                split_reg <= (req_reg.mode == ffa_pkg::MODE_ALLOC) && (tail != 33'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.eval)
        begin
            hit_idx_reg  <= idx_reg[IW-1:0];
            hit_off_reg  <= aligned_off;
            hit_tail_reg <= tail[31:0];
        end
        if (cmd.set_result)
        begin
            if (hit_reg && !(split_reg && count_reg >= CW'(MAX_BLOCKS)))
            begin
                result_reg.status <= ffa_pkg::ST_OK;
            end
            else if (hit_reg)
            begin
                result_reg.status <= ffa_pkg::ST_FULL;
            end
            else if (req_reg.mode == ffa_pkg::MODE_FREE)
            begin
                result_reg.status <= ffa_pkg::ST_NOTFOUND;
            end
            else
            begin
                result_reg.status <= ffa_pkg::ST_NOFIT;
            end
            if (hit_reg && req_reg.mode == ffa_pkg::MODE_ALLOC
                && !(split_reg && count_reg >= CW'(MAX_BLOCKS)))
            begin
                result_reg.grant_offset <= hit_off_reg;
                result_reg.grant_size   <= req_reg.req_size;
            end
            else
            begin
                result_reg.grant_offset <= '0;
                result_reg.grant_size   <= '0;
            end
        end
    end

    assign stat.oversize   = (req_reg.mode == ffa_pkg::MODE_ALLOC)
                             && (req_reg.req_size > arena_size);
    assign stat.scan_done  = (idx_reg >= count_reg);
    assign stat.hit        = hit_reg;
    assign stat.need_split = split_reg;
    assign stat.table_full = (count_reg >= CW'(MAX_BLOCKS));
    assign result          = result_reg;

endmodule

FILE: rtl/core/ffa_ctrl.sv
// Controller: sequences scan, write-back and result handshake
`include "first_fit_aligned_block_allocator_assert.svh"

module ffa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic               cfg_we,
    output ffa_pkg::dp_cmd_t   cmd,
    input  ffa_pkg::dp_stat_t  stat
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_READ, S_EVAL, S_WRITE, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    logic in_acc;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.init_table = cfg_we;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.oversize ? S_DONE : S_READ;
            end
            S_READ:
            begin
                // the table read is always running at the scan index
                if (stat.scan_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // hit: commit unless the split cannot fit
                if (stat.hit)
                begin
                    if (!(stat.need_split && stat.table_full))
                    begin
                        cmd.commit = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_DONE:
            begin
                if (stat.hit && stat.need_split && !stat.table_full)
                begin
                    cmd.split = 1'b1;
                end
                cmd.set_result = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `FFA_ASSERT_IMPL(a_accept_idle, clk, rst_n, in_acc, state_reg == S_IDLE, "accept outside idle")
    `FFA_ASSERT_NEXT(a_done_valid, clk, rst_n, state_reg == S_DONE, out_valid_reg, "result not shown")
    `FFA_ASSERT_IMPL(a_no_full_commit, clk, rst_n, cmd.commit, !(stat.need_split && stat.table_full), "commit on full table")

endmodule

FILE: rtl/core/first_fit_aligned_block_allocator.sv
// Top level of the first-fit aligned block allocator
// Usage:
//   Input channel in_valid / in_stall / in_data carries one request transaction
//   (allocate or free). Output channel out_valid / out_stall / out_data returns
//   one status transaction per request. cfg_we / cfg_data write arena_size and
//   rebuild the table as one free block; write only while idle.
//   Sequencing: each request scans the table one entry at a time (read,
//   evaluate, decide) from entry zero until a hit or entry_count, with
//   setup, write-back and result steps around the scan. One request is in
//   flight at a time; the input stalls whenever the controller is not idle.
//   Reset: arena_size returns to 1 GiB and the table holds one free block;
//   entry zero is seeded during reset and at the first edge after release,
//   so the input stalls for that one cycle.
//   A stalled result holds in the output register; a new request is taken
//   once that result has been taken.
module first_fit_aligned_block_allocator #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ffa_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ffa_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data
);

    logic [31:0]       arena_reg;
    logic              init_pend_reg;
    logic              ctrl_stall;
    ffa_pkg::dp_cmd_t  cmd, cmd_dp;
    ffa_pkg::dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_reg     <= ffa_pkg::RESET_ARENA;
            init_pend_reg <= 1'b1;
        end
        else
        begin
            init_pend_reg <= 1'b0;
            if (cfg_we)
            begin
                arena_reg <= cfg_data;
            end
        end
    end

    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && !init_pend_reg),
        .in_stall  (ctrl_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign in_stall = ctrl_stall || init_pend_reg;

    // seed entry zero after reset
    always_comb
    begin
        cmd_dp = cmd;
        if (init_pend_reg)
        begin
            cmd_dp.init_table = 1'b1;
        end
    end

    ffa_datapath #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_dp),
        .stat       (stat),
        .req        (in_data),
        .arena_size (cfg_we ? cfg_data : arena_reg),
        .result     (out_data)
    );

endmodule
